// ----- hw/rtl/tci_pkg.sv -----
// Shared types and constants for the timestamped CV interpolator.
`timescale 1ns / 1ps
package tci_pkg;

	localparam int RING_AW    = 10;
	localparam int RING_DEPTH = 1 << RING_AW;
	localparam int CHANNELS   = 8;
	localparam int CODE_W     = 12;
	localparam int VAL_W      = 20;
	localparam int TIME_W     = 64;
	localparam int ROW_W      = CHANNELS * CODE_W;
	localparam int CH_W       = 3;
	localparam int FRAC_W     = 16;
	localparam int ACC_W      = 28;

	localparam logic CFG_SMOOTH_COEF  = 1'b0;
	localparam logic CFG_NUM_CHANNELS = 1'b1;

	localparam logic MODE_STORE  = 1'b0;
	localparam logic MODE_RENDER = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SRD,
		ST_SCMP,
		ST_DIV,
		ST_MUL1,
		ST_ADD1,
		ST_MUL2,
		ST_ADD2,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic store;
		logic load;
		logic rd;
		logic srch_next;
		logic hit;
		logic div_step;
		logic mul1;
		logic add1;
		logic mul2;
		logic add2;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic hit;
		logic last;
		logic div_done;
		logic ch_last;
		logic out_free;
	} sts_t;

endpackage

// ----- hw/rtl/tci_ctrl.sv -----
// Sequencer for scan store, history search, division and channel loop.
`timescale 1ns / 1ps
module tci_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_mode,
	input  tci_pkg::sts_t sts,
	output tci_pkg::cmd_t cmd
);
	import tci_pkg::*;

	state_t state_q, state_nx;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_nx;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_mode == MODE_RENDER) state_nx = sts.empty ? ST_OUT : ST_SRD;
			end
			ST_SRD: state_nx = ST_SCMP;
			ST_SCMP: begin
				if (sts.hit) state_nx = ST_DIV;
				else if (sts.last) state_nx = ST_OUT;
				else state_nx = ST_SRD;
			end
			ST_DIV: begin
				if (sts.div_done) state_nx = ST_MUL1;
			end
			ST_MUL1: state_nx = ST_ADD1;
			ST_ADD1: state_nx = ST_MUL2;
			ST_MUL2: state_nx = ST_ADD2;
			ST_ADD2: state_nx = sts.ch_last ? ST_OUT : ST_MUL1;
			ST_OUT: begin
				if (sts.out_free) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (in_valid) begin
					if (in_mode == MODE_STORE) cmd.store = 1'b1;
					else cmd.load = 1'b1;
				end
			end
			ST_SRD: cmd.rd = 1'b1;
			ST_SCMP: begin
				if (sts.hit) cmd.hit = 1'b1;
				else if (!sts.last) cmd.srch_next = 1'b1;
			end
			ST_DIV: cmd.div_step = 1'b1;
			ST_MUL1: cmd.mul1 = 1'b1;
			ST_ADD1: cmd.add1 = 1'b1;
			ST_MUL2: cmd.mul2 = 1'b1;
			ST_ADD2: cmd.add2 = 1'b1;
			ST_OUT: cmd.out_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

`ifndef SYNTHESIS
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free) else $error("result loaded over a pending one");
	a_cmp_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCMP |-> $past(state_q) == ST_SRD) else $error("compare without read");
	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && sts.div_done) |=> state_q == ST_MUL1)
		else $error("division did not hand over to channel loop");
`endif

endmodule

// ----- hw/rtl/tci_dp.sv -----
// Datapath: history ring, search registers, fraction divider, interpolation and lowpass.
`timescale 1ns / 1ps
module tci_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  tci_pkg::cmd_t                          cmd,
	output tci_pkg::sts_t                          sts,
	input  logic                                   cfg_we,
	input  logic                                   cfg_idx,
	input  logic [15:0]                            cfg_data,
	input  logic [tci_pkg::TIME_W-1:0]             in_time,
	input  logic [tci_pkg::ROW_W-1:0]              in_codes,
	input  logic                                   out_ready,
	output logic                                   out_valid,
	output logic                                   out_flag,
	output logic [tci_pkg::CHANNELS*tci_pkg::VAL_W-1:0] out_values
);
	import tci_pkg::*;

	// configuration
	logic [15:0] coef_q;
	logic [3:0]  nch_q;
	logic        primed_q;
	logic [3:0]  nc;

	// ring storage
	logic [TIME_W-1:0] time_mem [RING_DEPTH];
	logic [ROW_W-1:0]  code_mem [RING_DEPTH];
	logic [RING_AW-1:0] wp_q, j_q, rd_addr;
	logic [RING_AW:0]   cnt_q;
	logic [TIME_W-1:0]  rtime_q, ptime_q, t_q;
	logic [ROW_W-1:0]   rrow_q, prow_q, arow_q, brow_q;
	logic               have_b_q, div_en_q, found_q, prime_q;

	// divider
	logic [TIME_W-1:0] rem_q, span_q, rem2;
	logic [FRAC_W-1:0] frac_q;
	logic [3:0]        dcnt_q;
	logic              ge;

	// channel loop
	logic [CH_W-1:0]        ch_q;
	logic [CODE_W-1:0]      a_ch, b_ch;
	logic signed [CODE_W:0] diff;
	logic signed [30:0]     prod_q;
	logic signed [30:0]     vsum;
	logic [ACC_W-1:0]       v_q, zin;
	logic [ACC_W-1:0]       zst_q [CHANNELS];
	logic [VAL_W-1:0]       last_q [CHANNELS];
	logic [VAL_W-1:0]       res_q [CHANNELS];
	logic [44:0]            p1_q;
	logic [43:0]            p2_q;
	logic [45:0]            zsum;
	logic [ACC_W-1:0]       znew, vout;
	logic                   ch_on;

	assign nc    = (nch_q > 4'(CHANNELS)) ? 4'(CHANNELS) : nch_q;
	assign ch_on = {1'b0, ch_q} < nc;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
			nch_q  <= 4'(CHANNELS);
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_SMOOTH_COEF:  coef_q <= cfg_data;
				CFG_NUM_CHANNELS: nch_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// ring write and read ports
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			time_mem[wp_q] <= in_time;
			code_mem[wp_q] <= in_codes;
		end
	end

	assign rd_addr = wp_q - RING_AW'(1) - j_q;

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rtime_q <= time_mem[rd_addr];
			rrow_q  <= code_mem[rd_addr];
		end
	end

	// ring pointers and search control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			cnt_q    <= '0;
			j_q      <= '0;
			found_q  <= 1'b0;
			primed_q <= 1'b0;
			prime_q  <= 1'b0;
			have_b_q <= 1'b0;
			div_en_q <= 1'b0;
			dcnt_q   <= '0;
			ch_q     <= '0;
		end else begin
			if (cfg_we && cfg_idx == CFG_SMOOTH_COEF) primed_q <= 1'b0;
			if (cmd.store) begin
				wp_q <= wp_q + RING_AW'(1);
				if (cnt_q != (RING_AW+1)'(RING_DEPTH)) cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.load) begin
				j_q     <= '0;
				found_q <= 1'b0;
			end
			if (cmd.srch_next) j_q <= j_q + RING_AW'(1);
			if (cmd.hit) begin
				found_q  <= 1'b1;
				have_b_q <= j_q != '0;
				div_en_q <= (j_q != '0) && (ptime_q > rtime_q);
				dcnt_q   <= '0;
				ch_q     <= '0;
				prime_q  <= (coef_q != '0) && !primed_q;
				if (coef_q != '0) primed_q <= 1'b1;
			end
			if (cmd.div_step) dcnt_q <= dcnt_q + 1'b1;
			if (cmd.add2) ch_q <= ch_q + 1'b1;
		end
	end

	// search payload
	always_ff @(posedge clk) begin
		if (cmd.load) t_q <= in_time;
		if (cmd.srch_next) begin
			ptime_q <= rtime_q;
			prow_q  <= rrow_q;
		end
		if (cmd.hit) begin
			arow_q <= rrow_q;
			brow_q <= prow_q;
			rem_q  <= t_q - rtime_q;
			span_q <= ptime_q - rtime_q;
			frac_q <= '0;
		end else if (cmd.div_step && div_en_q) begin
			rem_q  <= ge ? rem2 - span_q : rem2;
			frac_q <= {frac_q[FRAC_W-2:0], ge};
		end
	end

	// one restoring division step
	assign rem2 = {rem_q[TIME_W-2:0], 1'b0};
	assign ge   = rem_q[TIME_W-1] || (rem2 >= span_q);

	// interpolation and lowpass arithmetic
	assign a_ch = arow_q[ch_q*CODE_W +: CODE_W];
	assign b_ch = have_b_q ? brow_q[ch_q*CODE_W +: CODE_W] : a_ch;
	assign diff = $signed({1'b0, b_ch}) - $signed({1'b0, a_ch});
	assign vsum = $signed({3'b000, a_ch, 16'h0000}) + prod_q;
	assign zin  = prime_q ? {a_ch, 16'h0000} : zst_q[ch_q];
	assign zsum = 46'(p1_q) + 46'(p2_q);
	assign znew = zsum[16 +: ACC_W];
	assign vout = (coef_q != '0) ? znew : v_q;

	always_ff @(posedge clk) begin
		if (cmd.mul1) prod_q <= 31'(diff) * 31'($signed({1'b0, frac_q}));
		if (cmd.add1) v_q <= vsum[ACC_W-1:0];
		if (cmd.mul2) begin
			p1_q <= 45'(zin) * 45'(17'h10000 - {1'b0, coef_q});
			p2_q <= 44'(v_q) * 44'(coef_q);
		end
		if (cmd.add2) res_q[ch_q] <= ch_on ? vout[ACC_W-1:8] : '0;
	end

	// per-channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				zst_q[i]  <= '0;
				last_q[i] <= '0;
			end
		end else if (cmd.add2 && ch_on) begin
			if (coef_q != '0) zst_q[ch_q] <= znew;
			last_q[ch_q] <= vout[ACC_W-1:8];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.out_load) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_flag <= found_q;
			for (int i = 0; i < CHANNELS; i++) begin
				if (found_q) out_values[i*VAL_W +: VAL_W] <= res_q[i];
				else if (4'(i) < nc) out_values[i*VAL_W +: VAL_W] <= last_q[i];
				else out_values[i*VAL_W +: VAL_W] <= '0;
			end
		end
	end

	// status
	assign sts.empty    = cnt_q == '0;
	assign sts.hit      = rtime_q <= t_q;
	assign sts.last     = {1'b0, j_q} == cnt_q - 1'b1;
	assign sts.div_done = dcnt_q == 4'hF;
	assign sts.ch_last  = ch_q == CH_W'(CHANNELS - 1);
	assign sts.out_free = !out_valid || out_ready;

`ifndef SYNTHESIS
	a_cnt_sat: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (RING_AW+1)'(RING_DEPTH)) else $error("scan count beyond ring depth");
	a_search_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> cnt_q != '0) else $error("search on empty ring");
	a_found_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hit |=> found_q) else $error("hit not recorded");
`endif

endmodule

// ----- hw/rtl/timestamped_cv_interpolator_unit.sv -----
// Top level of the timestamped CV interpolator.
// Usage:
//  s_axis carries requests: tuser is the mode (0 stores a scan, 1 renders a frame),
//  tdata is time_ns then code_0..code_7. A store gives no result.
//  A render searches the history ring newest to oldest, a read and a compare per
//  scan looked at, then runs the fraction divider and, for each channel, a multiply
//  and add for interpolation and another for the lowpass, then loads the output
//  register. An empty ring, or a time older than every stored scan, goes straight
//  to the output register with the held last values.
//  m_axis carries one result per render: tuser is valid_res, tdata value_0..7.
//  The result waits in an output register; while m_axis_tready is low the block
//  holds it and can accept stores and start the next render, which stalls at its end.
//  Reset clears pointers, scan count, lowpass state and last values; history
//  contents are not cleared and need no clearing pass.
//  Configuration writes (cfg_we, cfg_idx, cfg_data) must go in while the block is
//  idle; the block itself does not enforce this.
`timescale 1ns / 1ps
module timestamped_cv_interpolator_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [159:0] s_axis_tdata,  // time_ns[63:0], code_0..code_7 [75:64]..[159:148]
	input  logic         s_axis_tuser,  // mode
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [159:0] m_axis_tdata,  // value_0..value_7, 20 bits each from bit 0
	output logic         m_axis_tuser,  // valid_res
	input  logic         cfg_we,
	input  logic         cfg_idx,
	input  logic [15:0]  cfg_data
);
	import tci_pkg::*;

	cmd_t cmd;
	sts_t sts;

	tci_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_mode  (s_axis_tuser),
		.sts      (sts),
		.cmd      (cmd)
	);

	tci_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.in_time    (s_axis_tdata[TIME_W-1:0]),
		.in_codes   (s_axis_tdata[TIME_W +: ROW_W]),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_flag   (m_axis_tuser),
		.out_values (m_axis_tdata)
	);

	assign s_axis_tready = cmd.in_ready;

endmodule

// ----- tb/tb_timestamped_cv_interpolator_unit.sv -----
// Self-checking testbench for the timestamped CV interpolator: scan history, fractional interpolation, lowpass.
`timescale 1ns / 1ps
module tb_timestamped_cv_interpolator_unit;
	import tci_pkg::*;

	typedef struct {
		logic        mode;
		logic [63:0] tstamp;
		logic [11:0] code [CHANNELS];
	} req_t;

	typedef struct {
		logic        interp_ok;
		logic [19:0] value [CHANNELS];
	} frame_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [159:0] s_axis_tdata;   // time_ns, code_0..code_7
	logic         s_axis_tuser;   // mode
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [159:0] m_axis_tdata;   // value_0..value_7
	logic         m_axis_tuser;   // valid_res
	logic         cfg_we;
	logic         cfg_idx;
	logic [15:0]  cfg_data;

	timestamped_cv_interpolator_unit uut (.*);

	// predictor state
	logic [63:0] hist_time [RING_DEPTH];
	logic [11:0] hist_code [RING_DEPTH][CHANNELS];
	int unsigned wr_ptr, n_scans;
	logic [27:0] lp_state [CHANNELS];
	logic        lp_primed;
	logic [19:0] held_value [CHANNELS];
	logic [15:0] lp_coef;
	logic [3:0]  chan_count;

	req_t   pending_reqs [$];
	frame_t expected_frames [$];
	int     n_errors, n_frames, n_renders, n_stores;
	longint cycle_cnt;
	bit     no_idle;
	int     src_gap, snk_gap;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

	// floor(d*65536/span), d < span
	function automatic logic [15:0] frac_of(logic [63:0] d, logic [63:0] span);
		logic [79:0] num;
		num = {d, 16'h0};
		return 16'(num / {16'h0, span});
	endfunction

	// apply one accepted request to the predictor
	task automatic predict(input req_t r);
		int unsigned nc, k, pa, pb;
		bit hit, has_next;
		logic [15:0] f;
		longint a, b;
		logic [63:0] v, z;
		frame_t e;
		pa = 0; pb = 0; hit = 0; has_next = 0; f = 0;
		nc = (chan_count > CHANNELS) ? CHANNELS : chan_count;
		if (r.mode == MODE_STORE) begin
			hist_time[wr_ptr] = r.tstamp;
			for (int c = 0; c < CHANNELS; c++) hist_code[wr_ptr][c] = r.code[c];
			wr_ptr = (wr_ptr + 1) % RING_DEPTH;
			if (n_scans < RING_DEPTH) n_scans++;
			return;
		end
		for (k = n_scans; k > 0; k--) begin
			pa = (wr_ptr + RING_DEPTH - n_scans + k - 1) % RING_DEPTH;
			if (hist_time[pa] <= r.tstamp) begin
				hit = 1;
				if (k < n_scans) begin
					has_next = 1;
					pb = (wr_ptr + RING_DEPTH - n_scans + k) % RING_DEPTH;
				end
				break;
			end
		end
		e.interp_ok = 0;
		for (int c = 0; c < CHANNELS; c++) e.value[c] = '0;
		if (!hit) begin
			for (int c = 0; c < nc; c++) e.value[c] = held_value[c];
			expected_frames.push_back(e);
			return;
		end
		if (has_next && hist_time[pb] > hist_time[pa])
			f = frac_of(r.tstamp - hist_time[pa], hist_time[pb] - hist_time[pa]);
		if (lp_coef != 0 && !lp_primed) begin
			for (int c = 0; c < nc; c++) lp_state[c] = {hist_code[pa][c], 16'h0};
			lp_primed = 1;
		end
		e.interp_ok = 1;
		for (int c = 0; c < nc; c++) begin
			a = hist_code[pa][c];
			b = has_next ? hist_code[pb][c] : a;
			v = a * 65536 + (b - a) * longint'(f);
			if (lp_coef != 0) begin
				z = (64'(lp_state[c]) * (65536 - lp_coef) + v * lp_coef) >> 16;
				lp_state[c] = z[27:0];
				v = 64'(lp_state[c]);
			end
			held_value[c] = v[27:8];
			e.value[c] = v[27:8];
		end
		expected_frames.push_back(e);
	endtask

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0h want %0h (frame %0d)", what, got, want, n_frames);
		n_errors++;
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 0;
			src_gap <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) predict(pending_reqs.pop_front());
			if (s_axis_tvalid && !s_axis_tready) begin
				// hold current request
			end else if (src_gap > 0) begin
				s_axis_tvalid <= 0;
				src_gap <= src_gap - 1;
			end else if (!no_idle && $urandom_range(0, 9) == 0) begin
				s_axis_tvalid <= 0;
				src_gap <= $urandom_range(1, 15) - 1;
			end else if (pending_reqs.size() > (s_axis_tvalid && s_axis_tready ? 0 : 0)) begin
				s_axis_tvalid <= 1;
				s_axis_tuser <= pending_reqs[0].mode;
				s_axis_tdata[63:0] <= pending_reqs[0].tstamp;
				for (int c = 0; c < CHANNELS; c++)
					s_axis_tdata[64 + 12*c +: 12] <= pending_reqs[0].code[c];
			end else s_axis_tvalid <= 0;
		end
	end

	// result monitor and stall generator
	always @(posedge clk or negedge arst_n) begin
		frame_t e;
		if (!arst_n) begin
			m_axis_tready <= 0;
			snk_gap <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_frames.size() == 0) begin
					report("unexpected frame", 0, 0);
				end else begin
					e = expected_frames.pop_front();
					if (m_axis_tuser !== e.interp_ok) report("valid_res", m_axis_tuser, e.interp_ok);
					for (int c = 0; c < CHANNELS; c++)
						if (m_axis_tdata[20*c +: 20] !== e.value[c])
							report($sformatf("value_%0d", c), m_axis_tdata[20*c +: 20], e.value[c]);
				end
				n_frames++;
			end
			if (snk_gap > 0) begin
				m_axis_tready <= 0;
				snk_gap <= snk_gap - 1;
			end else if (!no_idle && $urandom_range(0, 7) == 0) begin
				m_axis_tready <= 0;
				snk_gap <= $urandom_range(1, 15) - 1;
			end else m_axis_tready <= 1;
		end
	end

	function automatic req_t mk_req(logic m, logic [63:0] t);
		req_t r;
		r.mode = m;
		r.tstamp = t;
		for (int c = 0; c < CHANNELS; c++) r.code[c] = 12'($urandom);
		return r;
	endfunction

	function automatic logic [63:0] rand64();
		return {32'($urandom), 32'($urandom)};
	endfunction

	task automatic push(logic m, logic [63:0] t);
		pending_reqs.push_back(mk_req(m, t));
		if (m == MODE_RENDER) n_renders++; else n_stores++;
	endtask

	task automatic push_codes(logic [63:0] t, logic [11:0] v);
		req_t r;
		r = mk_req(MODE_STORE, t);
		for (int c = 0; c < CHANNELS; c++) r.code[c] = v;
		pending_reqs.push_back(r);
		n_stores++;
	endtask

	// let all queued requests drain, then settle
	task automatic drain();
		wait (pending_reqs.size() == 0 && !s_axis_tvalid);
		wait (expected_frames.size() == 0);
		repeat (2 * RING_DEPTH + 100) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1; cfg_idx <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		if (idx == CFG_SMOOTH_COEF) begin
			lp_coef = val;
			lp_primed = 0;
		end else chan_count = val[3:0];
	endtask

	// random phase: ordered timeline of scans with frames between them, plus occasional requests at random times
	task automatic random_phase(int n_items, logic [63:0] start, int step_max);
		logic [63:0] t;
		t = start;
		for (int i = 0; i < n_items; i++) begin
			case ($urandom_range(0, 19))
				0: push($urandom_range(0, 1), rand64());
				1: push(MODE_RENDER, t - $urandom_range(0, 3 * step_max));
				default: begin
					if ($urandom_range(0, 2) == 0) begin
						t = t + $urandom_range(1, step_max);
						push(MODE_STORE, t);
					end else push(MODE_RENDER, t + $urandom_range(0, step_max));
				end
			endcase
		end
	endtask

	// watchdog
	initial begin
		wait (cycle_cnt > 20_000_000);
		$display("timeout after %0d cycles", cycle_cnt);
		$display("tb_timestamped_cv_interpolator_unit: FAIL");
		$finish;
	end

	initial begin
		cycle_cnt = 0; n_errors = 0; n_frames = 0; n_renders = 0; n_stores = 0;
		no_idle = 0;
		s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = 0; m_axis_tready = 0;
		cfg_we = 0; cfg_idx = 0; cfg_data = '0;
		wr_ptr = 0; n_scans = 0; lp_primed = 0; lp_coef = 0; chan_count = 8;
		for (int c = 0; c < CHANNELS; c++) begin
			lp_state[c] = '0;
			held_value[c] = '0;
		end
		arst_n = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;

		// directed: empty ring, extremes, old time, unordered stamps, interpolation
		push(MODE_RENDER, 64'd0);
		push(MODE_RENDER, '1);
		push_codes(64'd1000, 12'h000);
		push_codes(64'd2000, 12'hFFF);
		push(MODE_RENDER, 64'd999);
		push(MODE_RENDER, 64'd1000);
		push(MODE_RENDER, 64'd1500);
		push(MODE_RENDER, 64'd1999);
		push(MODE_RENDER, 64'd2000);
		push(MODE_RENDER, '1);
		push_codes(64'd500, 12'hA5A);
		push(MODE_RENDER, 64'd1700);
		push(MODE_RENDER, 64'd400);
		push_codes('1, 12'h5A5);
		push_codes(64'h8000_0000_0000_0000, 12'hFFF);
		push(MODE_RENDER, '1 - 1);
		push(MODE_RENDER, 64'hC000_0000_0000_0000);
		push(MODE_RENDER, 64'd0);
		drain();

		// settings sweep, extremes included
		write_reg(CFG_SMOOTH_COEF, 16'hFFFF);
		write_reg(CFG_NUM_CHANNELS, 4'd1);
		random_phase(100, 64'd10_000, 1000);
		drain();
		write_reg(CFG_SMOOTH_COEF, 16'h0001);
		write_reg(CFG_NUM_CHANNELS, 4'd15);
		random_phase(100, 64'h7FFF_FFFF_0000_0000, 1 << 30);
		drain();
		write_reg(CFG_SMOOTH_COEF, 16'h4000);
		write_reg(CFG_NUM_CHANNELS, 4'd0);
		random_phase(60, 64'd1, 50);
		drain();
		write_reg(CFG_SMOOTH_COEF, 16'($urandom_range(1, 65535)));
		write_reg(CFG_NUM_CHANNELS, 4'($urandom_range(1, 8)));
		// long run of scans builds a deep history
		for (int i = 0; i < 400; i++) push(MODE_STORE, 64'd5_000_000 + 64'(i) * 97);
		random_phase(100, 64'd5_000_000 + 64'd400 * 97, 500);
		push(MODE_RENDER, 64'd5_000_000 + 64'd80 * 97);
		push(MODE_RENDER, 64'd5_000_000 + 64'd77 * 97 + 13);
		drain();
		write_reg(CFG_SMOOTH_COEF, 16'h0000);
		write_reg(CFG_NUM_CHANNELS, 4'd8);
		random_phase(80, 64'd9_000_000, 3000);
		no_idle = 1;
		random_phase(80, 64'd9_900_000, 3000);
		drain();

		$display("covered %0d stores and %0d renders, %0d frames checked",
			n_stores, n_renders, n_frames);
		$display("settings swept: lowpass off/min/max/mid, 0..15 channels, deep history search");
		if (n_errors == 0 && expected_frames.size() == 0)
			$display("tb_timestamped_cv_interpolator_unit: PASS");
		else
			$display("tb_timestamped_cv_interpolator_unit: FAIL");
		$finish;
	end

endmodule
